[hdl/cu_pkg.sv]
package cu_pkg;

	localparam int MAX_SIZE = 8;
	localparam int RANK_W   = 32;
	localparam int SIZE_W   = 4;
	localparam int POS_W    = 3;
	localparam int FACT_W   = 16;
	localparam int LIM_W    = RANK_W + FACT_W;
	// for sizes of two and up the element stays below this cap
	localparam int SRCH_W   = 18;
	localparam logic [SRCH_W-1:0] SRCH_CAP = SRCH_W'(1 << 17);
	localparam int MUL_W    = LIM_W + SRCH_W;
	localparam int CNT_W    = 6;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(LIM_W - 1);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SETUP,
		OP_START_MID,
		OP_START_FINAL,
		OP_STEP,
		OP_DECIDE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_NEXT
	} cu_op_t;

	typedef struct packed {
		cu_op_t op;
	} cu_cmd_t;

	typedef struct packed {
		logic i_one;
		logic search_done;
		logic step_last;
		logic div_last;
	} cu_status_t;

	function automatic logic [FACT_W-1:0] fact(input logic [SIZE_W-1:0] n);
		logic [FACT_W-1:0] f;
		case (n)
			4'd2: f = 16'd2;
			4'd3: f = 16'd6;
			4'd4: f = 16'd24;
			4'd5: f = 16'd120;
			4'd6: f = 16'd720;
			4'd7: f = 16'd5040;
			4'd8: f = 16'd40320;
			default: f = 16'd1;
		endcase
		return f;
	endfunction

endpackage

[hdl/cu_if.sv]
interface cu_in_if;
	logic                        valid;
	logic                        ready;
	logic [cu_pkg::RANK_W-1:0]   rank;
	logic [cu_pkg::SIZE_W-1:0]   comb_size;

	modport source (output valid, rank, comb_size, input ready);
	modport sink (input valid, rank, comb_size, output ready);
endinterface

interface cu_out_if;
	logic                        valid;
	logic                        ready;
	logic [cu_pkg::POS_W-1:0]    position;
	logic [cu_pkg::RANK_W-1:0]   element;
	logic                        last;

	modport source (output valid, position, element, last, input ready);
	modport sink (input valid, position, element, last, output ready);
endinterface

[hdl/cu_datapath.sv]
module cu_datapath (
	input  logic                        clk,
	input  cu_pkg::cu_cmd_t             cmd,
	input  logic [cu_pkg::RANK_W-1:0]   rank,
	input  logic [cu_pkg::SIZE_W-1:0]   comb_size,
	output cu_pkg::cu_status_t          status,
	output logic [cu_pkg::POS_W-1:0]    position,
	output logic [cu_pkg::RANK_W-1:0]   element,
	output logic                        last
);
	import cu_pkg::*;

	logic [RANK_W-1:0] rank_q;
	logic [SIZE_W-1:0] i_q;
	logic [SIZE_W-1:0] j_q;
	logic [LIM_W-1:0]  lim_q;
	logic [SRCH_W-1:0] lo_q;
	logic [SRCH_W-1:0] hi_q;
	logic [SRCH_W-1:0] mid_q;
	logic [LIM_W-1:0]  prod_q;
	logic              over_q;
	logic [LIM_W-1:0]  dvd_q;
	logic [FACT_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RANK_W-1:0] elem_q;

	logic [SRCH_W-1:0] x;
	logic [MUL_W-1:0]  mul;
	logic [RANK_W:0]   hi_sum;
	logic [FACT_W:0]   trial;
	logic [FACT_W-1:0] fi;
	logic              ge;

	assign fi     = fact(i_q);
	assign x      = mid_q + SRCH_W'(j_q) - SRCH_W'(i_q);
	assign mul    = MUL_W'(prod_q) * MUL_W'(x);
	assign hi_sum = {1'b0, rank_q} + (RANK_W+1)'(i_q) - (RANK_W+1)'(1);
	assign trial  = {rem_q, dvd_q[LIM_W-1]};
	assign ge     = trial >= {1'b0, fi};

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				rank_q <= rank;
				i_q    <= (comb_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : comb_size;
			end
			OP_SETUP: begin
				lim_q  <= LIM_W'(rank_q) * LIM_W'(fi);
				lo_q   <= SRCH_W'(i_q) - SRCH_W'(1);
				hi_q   <= (hi_sum > (RANK_W+1)'(SRCH_CAP)) ? SRCH_CAP : hi_sum[SRCH_W-1:0];
				// size one: the element is the rank itself
				elem_q <= rank_q;
				dvd_q  <= LIM_W'(rank_q);
			end
			OP_START_MID: begin
				mid_q  <= lo_q + ((hi_q - lo_q + SRCH_W'(1)) >> 1);
				prod_q <= LIM_W'(1);
				j_q    <= SIZE_W'(1);
				over_q <= 1'b0;
			end
			OP_START_FINAL: begin
				mid_q  <= lo_q;
				prod_q <= LIM_W'(1);
				j_q    <= SIZE_W'(1);
				over_q <= 1'b0;
			end
			OP_STEP: begin
				j_q <= j_q + SIZE_W'(1);
				if (!over_q) begin
					if (mul > MUL_W'(lim_q))
						over_q <= 1'b1;
					else
						prod_q <= mul[LIM_W-1:0];
				end
			end
			OP_DECIDE: begin
				if (over_q)
					hi_q <= mid_q - SRCH_W'(1);
				else
					lo_q <= mid_q;
			end
			OP_DIV_INIT: begin
				dvd_q  <= prod_q;
				rem_q  <= '0;
				cnt_q  <= '0;
				elem_q <= RANK_W'(mid_q);
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? (trial[FACT_W-1:0] - fi) : trial[FACT_W-1:0];
				dvd_q <= {dvd_q[LIM_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_NEXT: begin
				rank_q <= rank_q - dvd_q[RANK_W-1:0];
				i_q    <= i_q - SIZE_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign status.i_one       = i_q == SIZE_W'(1);
	assign status.search_done = lo_q >= hi_q;
	assign status.step_last   = j_q == i_q;
	assign status.div_last    = cnt_q == DIV_LAST;

	assign position = POS_W'(i_q - SIZE_W'(1));
	assign element  = elem_q;
	assign last     = i_q == SIZE_W'(1);
endmodule

[hdl/cu_ctrl.sv]
module cu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [cu_pkg::SIZE_W-1:0]   in_size,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  cu_pkg::cu_status_t          status,
	output cu_pkg::cu_cmd_t             cmd
);
	import cu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_SEARCH,
		S_EVAL,
		S_DECIDE,
		S_FEVAL,
		S_DIVI,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_EMIT;

	always_comb begin
		cmd.op = OP_NOP;
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
			S_SETUP:  cmd.op = OP_SETUP;
			S_SEARCH: cmd.op = status.search_done ? OP_START_FINAL : OP_START_MID;
			S_EVAL:   cmd.op = OP_STEP;
			S_DECIDE: cmd.op = OP_DECIDE;
			S_FEVAL:  cmd.op = OP_STEP;
			S_DIVI:   cmd.op = OP_DIV_INIT;
			S_DIV:    cmd.op = OP_DIV_STEP;
			S_EMIT:   if (out_ready) cmd.op = OP_NEXT;
			default:  cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid && in_size != '0) state_q <= S_SETUP;
				S_SETUP:  state_q <= status.i_one ? S_EMIT : S_SEARCH;
				S_SEARCH: state_q <= status.search_done ? S_FEVAL : S_EVAL;
				S_EVAL:   if (status.step_last) state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_SEARCH;
				S_FEVAL:  if (status.step_last) state_q <= S_DIVI;
				S_DIVI:   state_q <= S_DIV;
				S_DIV:    if (status.div_last) state_q <= S_EMIT;
				S_EMIT: begin
					if (out_ready)
						state_q <= status.i_one ? S_IDLE : S_SETUP;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/combination_unrank_core.sv]
// Combination unranking in the combinatorial number system. Each input word
// carries a rank and a size m (sizes above 8 count as 8, size 0 gives no
// output). The core returns m output words, position m-1 down to 0, each
// holding the largest element c with binomial(c, position+1) not above the
// remaining rank; last marks position 0. One item is worked at a time. A
// position of size k >= 2 runs a binary search of up to 17 probes, each
// evaluating the binomial with k steps of the shared 48x18 multiplier, then
// a shift-subtract divide of the 48-bit product by k! to get the amount
// taken off the rank. Position 0 needs no search or divide. One output
// word waits per position.
module combination_unrank_core (
	input  logic      clk,
	input  logic      arst_n,
	cu_in_if.sink     items,
	cu_out_if.source  results
);
	import cu_pkg::*;

	cu_cmd_t    cmd;
	cu_status_t status;

	// sequence the search, evaluate, divide and emit steps
	cu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_size   (items.comb_size),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// hold rank, search bounds, binomial product and divider registers
	cu_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.rank      (items.rank),
		.comb_size (items.comb_size),
		.status    (status),
		.position  (results.position),
		.element   (results.element),
		.last      (results.last)
	);
endmodule

[tb/tb_cu_checker.sv]
module tb_cu_checker (
	input  logic        clk,
	input  logic        arst_n,
	cu_in_if.sink       items,
	cu_out_if.sink      results,
	output int          errors,
	output int          pending,
	output int          words_seen
);
	import cu_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [RANK_W-1:0] element;
		logic              last;
	} elem_word_t;

	elem_word_t elem_q[$];

	// binomial(c, i), saturated to limit+1 once it passes limit
	function automatic longint unsigned sat_binom(longint unsigned c, longint unsigned i,
			longint unsigned limit);
		longint unsigned b;
		longint unsigned x;
		b = 1;
		if (c < i) return 0;
		for (longint unsigned j = 1; j <= i; j++) begin
			x = c - i + j;
			if (b > (64'hFFFF_FFFF_FFFF_FFFF / x)) return limit + 1;
			b = (b * x) / j;
			if (b > limit) return limit + 1;
		end
		return b;
	endfunction

	function automatic longint unsigned find_element(longint unsigned r, longint unsigned i);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = i - 1;
		hi = r + i - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (sat_binom(mid, i, r) <= r) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic unrank(input logic [RANK_W-1:0] rank, input logic [SIZE_W-1:0] size);
		longint unsigned r;
		longint unsigned m;
		longint unsigned c;
		elem_word_t w;
		r = rank;
		m = (size > MAX_SIZE) ? MAX_SIZE : size;
		for (longint unsigned i = m; i >= 1; i--) begin
			c = find_element(r, i);
			r -= sat_binom(c, i, r);
			w.position = POS_W'(i - 1);
			w.element  = RANK_W'(c);
			w.last     = (i == 1);
			elem_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		elem_word_t exp_w;
		int err_n;
		err_n = 0;
		if (!arst_n) begin
			errors <= 0;
			words_seen <= 0;
			pending <= 0;
		end else begin
			if (items.valid && items.ready)
				unrank(items.rank, items.comb_size);
			if (results.valid && results.ready) begin
				words_seen <= words_seen + 1;
				if (elem_q.size() == 0) begin
					$error("unexpected result word, position %0d element %0d",
						results.position, results.element);
					err_n++;
				end else begin
					exp_w = elem_q.pop_front();
					if (exp_w.position !== results.position) begin
						$error("position: expected %0d actual %0d", exp_w.position,
							results.position);
						err_n++;
					end
					if (exp_w.element !== results.element) begin
						$error("element: expected %0d actual %0d", exp_w.element,
							results.element);
						err_n++;
					end
					if (exp_w.last !== results.last) begin
						$error("last: expected %0b actual %0b", exp_w.last, results.last);
						err_n++;
					end
				end
			end
			errors <= errors + err_n;
			pending <= elem_q.size();
		end
	end
endmodule

[tb/tb_combination_unrank_core.sv]
module tb_combination_unrank_core;
	import cu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   words_seen;
	int   n_items = 0;
	bit   no_idle = 1'b0;
	bit   hold_off = 1'b0;

	cu_in_if  items();
	cu_out_if results();

	combination_unrank_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	tb_cu_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.results    (results),
		.errors     (errors),
		.pending    (pending),
		.words_seen (words_seen)
	);

	always #1 clk = ~clk;

	// Drive one word onto the input channel and hold it until the core takes it.
	// Idle cycles are inserted at random before the word unless the quiet stretch is on.
	task automatic send_word(input logic [RANK_W-1:0] rank, input logic [SIZE_W-1:0] size);
		while (!no_idle && $urandom_range(99) < 21) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid     <= 1'b1;
		items.rank      <= rank;
		items.comb_size <= size;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		n_items++;
		@(negedge clk);
	endtask

	// Pick a rank: half the time small (up to 63 or 65535), where elements stay small and vary a lot,
	// the other half full width so that every rank bit toggles.
	function automatic logic [RANK_W-1:0] pick_rank();
		case ($urandom_range(3))
			0: return RANK_W'($urandom_range(63));
			1: return RANK_W'($urandom_range(65535));
			default: return RANK_W'($urandom);
		endcase
	endfunction

	// Receiver: stall at random, except during the quiet stretch and the long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			results.ready <= 1'b0;
		else
			results.ready <= !hold_off && (no_idle || $urandom_range(99) >= 21);
	end

	// Long hold-off: once 60 items are sent, keep ready low while the core holds its output word.
	initial begin
		wait (n_items == 60);
		hold_off = 1'b1;
		repeat (6000) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		logic [RANK_W-1:0] rk[8];
		items.valid     = 1'b0;
		items.rank      = '0;
		items.comb_size = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes of rank and size, size zero, oversize, exhausted rank.
		rk = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd7, 32'd35, 32'h0001_0000,
			32'h7FFF_FFFF};
		foreach (rk[k]) send_word(rk[k], SIZE_W'(8));
		foreach (rk[k]) send_word(rk[k], SIZE_W'(1));
		send_word(32'd100, 4'd0);
		send_word(32'hFFFF_FFFF, 4'd15);
		send_word(32'd12345, 4'd9);
		send_word(32'hFFFF_FFFF, 4'd2);
		send_word(32'd0, 4'd15);
		send_word(32'd5, 4'd3);

		// Random: one early stretch with no idling on either side.
		for (int k = 0; k < 460; k++) begin
			no_idle = (k >= 120 && k < 180);
			send_word(pick_rank(), ($urandom_range(19) == 0) ? SIZE_W'($urandom_range(15))
				: SIZE_W'($urandom_range(8, 1)));
		end
		no_idle = 1'b0;
		items.valid <= 1'b0;

		// Drain: wait for every expected word, then a tail before the report.
		while (pending != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		$display("Sent %0d items (sizes 0..15, ranks from 0 to full width), %0d words checked.",
			n_items, words_seen);
		if (errors == 0 && pending == 0)
			$display("combination_unrank_core test passed");
		else
			$display("combination_unrank_core test failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("combination_unrank_core test failed");
		$finish;
	end
endmodule

[sim.f]
hdl/cu_pkg.sv
hdl/cu_if.sv
hdl/cu_datapath.sv
hdl/cu_ctrl.sv
hdl/combination_unrank_core.sv
tb/tb_cu_checker.sv
tb/tb_combination_unrank_core.sv
